// ===== hdl/rdc_pkg.sv =====
// Shared command and status codes for the range distinct count block.
package rdc_pkg;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

endpackage

// ===== hdl/rdc_if.sv =====
// Valid/ready channel interface carrying one word of payload.
interface rdc_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rdc_ram.sv =====
// Generic single-port RAM with registered read.
module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/range_distinct_count_core.sv =====
// Top level of the range distinct count block.
// A load searches the value table one entry at a time through its single RAM port, so its
// cost grows with the number of distinct values seen so far. For each element that the window
// moves, a query plans the step, reads the element, reads its count and writes the count back,
// so its cost follows the distance between consecutive query ranges. After reset and after a
// clear command the count table is swept clean, one entry per cycle, while no word is
// accepted; a clear word answers only when that sweep is done. Each input word gives one
// result word with status and, for a good query, the distinct count. The result sits in an
// output register; the next word is taken once it has been delivered.
module range_distinct_count_core #(
  parameter int MAX_ELEMS  = 4096,
  parameter int VALUE_BITS = 30
) (
  input logic clk,
  input logic rst,
  rdc_if.sink   in_ch,
  rdc_if.source out_ch
);
  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = AW + 1;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SRCH  = 9'b000000100,
    S_SCMP  = 9'b000001000,
    S_STORE = 9'b000010000,
    S_PLAN  = 9'b000100000,
    S_EREAD = 9'b001000000,
    S_CREAD = 9'b010000000,
    S_CUPD  = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0]  cmd;
  logic [29:0] val;
  logic [11:0] qs, qe;
  logic [CW-1:0] loaded, ndist, wdist, scan;
  logic [AW-1:0] wl, wr, pos;
  logic wopen, adding;
  logic [12:0] res_count;
  logic [1:0]  res_status;
  logic        res_valid;

  // RAM ports
  logic          e_we, v_we, c_we;
  logic [AW-1:0] e_addr, v_addr, c_addr;
  logic [AW-1:0] e_wd, e_rd;
  logic [VALUE_BITS-1:0] v_wd, v_rd;
  logic [CW-1:0] c_wd, c_rd;

  rdc_ram #(.WIDTH(AW), .DEPTH(MAX_ELEMS)) u_elem (
    .clk, .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rd));
  rdc_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMS)) u_val (
    .clk, .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
  rdc_ram #(.WIDTH(CW), .DEPTH(MAX_ELEMS)) u_cnt (
    .clk, .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

  logic [VALUE_BITS-1:0] vm;
  assign vm = VALUE_BITS'(val);

  // Input fields packed as {command, value, query_start, query_end}.
  assign in_ch.ready = (state == S_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = {res_count, res_status};

  // Wide query bounds compared against the stored length.
  logic [12:0] qs_w, qe_w;
  assign qs_w = 13'(qs);
  assign qe_w = 13'(qe);

  always_comb begin
    e_we = 1'b0; v_we = 1'b0; c_we = 1'b0;
    e_addr = pos; v_addr = scan[AW-1:0]; c_addr = e_rd;
    e_wd = scan[AW-1:0]; v_wd = vm; c_wd = '0;
    case (state)
      S_CLR: begin
        c_we = 1'b1; c_addr = scan[AW-1:0];
      end
      S_STORE: begin
        e_we = 1'b1; e_addr = loaded[AW-1:0];
        v_we = (scan == ndist); v_addr = scan[AW-1:0];
      end
      S_CUPD: begin
        c_we = 1'b1;
        c_wd = adding ? c_rd + 1'b1 : (c_rd != 0 ? c_rd - 1'b1 : c_rd);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; scan <= '0; loaded <= '0; ndist <= '0; wdist <= '0;
      wl <= '0; wr <= '0; wopen <= 1'b0; res_valid <= 1'b0; cmd <= rdc_pkg::CMD_LOAD;
      res_count <= '0; res_status <= rdc_pkg::ST_OK;
    end else begin
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_CLR: begin
          scan <= scan + 1'b1;
          if (scan == CW'(MAX_ELEMS - 1)) begin
            state <= S_IDLE;
            // Only a sweep started by a clear word answers; the one after reset does not.
            if (cmd == rdc_pkg::CMD_CLEAR) begin
              res_valid <= 1'b1; res_count <= '0; res_status <= rdc_pkg::ST_OK;
            end
          end
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            {cmd, val, qs, qe} <= in_ch.data;
            res_count <= '0;
            scan <= '0;
            case (in_ch.data[55:54])
              rdc_pkg::CMD_LOAD: begin
                if (loaded == CW'(MAX_ELEMS)) begin
                  res_status <= rdc_pkg::ST_FULL; res_valid <= 1'b1;
                end else begin
                  res_status <= rdc_pkg::ST_OK; state <= S_SRCH;
                end
              end
              rdc_pkg::CMD_QUERY: begin
                res_status <= rdc_pkg::ST_OK; state <= S_PLAN;
              end
              rdc_pkg::CMD_CLEAR: begin
                loaded <= '0; ndist <= '0; wdist <= '0; wl <= '0; wr <= '0;
                wopen <= 1'b0; res_status <= rdc_pkg::ST_OK; state <= S_CLR;
              end
              default: begin
                res_status <= rdc_pkg::ST_OK; res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SRCH: state <= (scan == ndist) ? S_STORE : S_SCMP;
        S_SCMP: begin
          if (v_rd == vm) state <= S_STORE;
          else begin scan <= scan + 1'b1; state <= S_SRCH; end
        end
        S_STORE: begin
          if (scan == ndist) ndist <= ndist + 1'b1;
          loaded <= loaded + 1'b1; res_valid <= 1'b1; state <= S_IDLE;
        end
        S_PLAN: begin
          if (qs > qe || qe_w >= loaded) begin
            res_status <= rdc_pkg::ST_BAD; res_valid <= 1'b1; state <= S_IDLE;
          end else if (!wopen) begin
            wopen <= 1'b1; wl <= AW'(qs); wr <= AW'(qs); wdist <= '0;
            pos <= AW'(qs); adding <= 1'b1; state <= S_EREAD;
          end else if (qs_w < 13'(wl)) begin
            wl <= wl - 1'b1; pos <= wl - 1'b1; adding <= 1'b1; state <= S_EREAD;
          end else if (qe_w > 13'(wr)) begin
            wr <= wr + 1'b1; pos <= wr + 1'b1; adding <= 1'b1; state <= S_EREAD;
          end else if (13'(wl) < qs_w) begin
            pos <= wl; wl <= wl + 1'b1; adding <= 1'b0; state <= S_EREAD;
          end else if (13'(wr) > qe_w) begin
            pos <= wr; wr <= wr - 1'b1; adding <= 1'b0; state <= S_EREAD;
          end else begin
            res_count <= 13'(wdist); res_valid <= 1'b1; state <= S_IDLE;
          end
        end
        S_EREAD: state <= S_CREAD;
        S_CREAD: state <= S_CUPD;
        S_CUPD: begin
          if (adding && c_rd == 0) wdist <= wdist + 1'b1;
          if (!adding && c_rd == 1) wdist <= wdist - 1'b1;
          state <= S_PLAN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== dv/range_distinct_count_core_tb.sv =====
// Testbench for range_distinct_count_core: directed and random words checked by a scoreboard.
`timescale 1ns / 100ps

class distinct_count_scoreboard;

  localparam int DEPTH = 4096;

  // Mirror of the block's state.
  int unsigned   elem_idx [DEPTH];
  bit [29:0]     seen_vals [DEPTH];
  int unsigned   occ [DEPTH];
  int unsigned   loaded;
  int unsigned   n_distinct;
  int unsigned   win_lo;
  int unsigned   win_hi;
  int unsigned   win_count;
  bit            win_valid;

  bit [14:0]     expected_results [$];
  int            mismatches;
  int            results_seen;

  function new();
    mismatches   = 0;
    results_seen = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (occ[i]) occ[i] = 0;
    loaded     = 0;
    n_distinct = 0;
    win_lo     = 0;
    win_hi     = 0;
    win_count  = 0;
    win_valid  = 0;
  endfunction

  function void grow(int unsigned pos);
    int unsigned k;
    k = elem_idx[pos];
    if (occ[k] == 0) win_count++;
    occ[k]++;
  endfunction

  function void shrink(int unsigned pos);
    int unsigned k;
    k = elem_idx[pos];
    if (occ[k] == 1) win_count--;
    if (occ[k] != 0) occ[k]--;
  endfunction

  // Works out the result of one accepted input word.
  function void note_word(bit [55:0] w);
    logic [1:0]  cmd;
    bit [29:0]   val;
    int unsigned qs;
    int unsigned qe;
    int unsigned i;
    bit [12:0]   cnt;
    bit [1:0]    st;
    cmd = w[55:54];
    val = w[53:24];
    qs  = 32'(w[23:12]);
    qe  = 32'(w[11:0]);
    cnt = '0;
    st  = rdc_pkg::ST_OK;
    case (cmd)
      rdc_pkg::CMD_LOAD: begin
        if (loaded >= DEPTH) begin
          st = rdc_pkg::ST_FULL;
        end else begin
          for (i = 0; i < n_distinct; i++)
            if (seen_vals[i] == val) break;
          if (i == n_distinct) begin
            seen_vals[i] = val;
            n_distinct++;
          end
          elem_idx[loaded] = i;
          loaded++;
        end
      end
      rdc_pkg::CMD_QUERY: begin
        if (qs > qe || qe >= loaded) begin
          st = rdc_pkg::ST_BAD;
        end else begin
          if (!win_valid) begin
            win_lo    = qs;
            win_hi    = qs;
            win_count = 0;
            grow(qs);
            win_valid = 1;
          end
          while (qs < win_lo) begin
            win_lo--;
            grow(win_lo);
          end
          while (qe > win_hi) begin
            win_hi++;
            grow(win_hi);
          end
          while (win_lo < qs) begin
            shrink(win_lo);
            win_lo++;
          end
          while (win_hi > qe) begin
            shrink(win_hi);
            win_hi--;
          end
          cnt = 13'(win_count);
        end
      end
      rdc_pkg::CMD_CLEAR: wipe();
      default: ;
    endcase
    expected_results.push_back({cnt, st});
  endfunction

  function void check_result(bit [14:0] got);
    bit [14:0] exp_r;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result count=%0d status=%0d with nothing expected",
                 got[14:2], got[1:0]);
      return;
    end
    exp_r = expected_results.pop_front();
    if (exp_r != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d: expected count=%0d status=%0d, got count=%0d status=%0d",
                 results_seen, exp_r[14:2], exp_r[1:0], got[14:2], got[1:0]);
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module range_distinct_count_core_tb;

  localparam int MAX_ELEMS = 4096;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst = 1'b1;

  rdc_if #(.W(56)) in_ch ();
  rdc_if #(.W(15)) out_ch ();

  range_distinct_count_core #(.MAX_ELEMS(MAX_ELEMS), .VALUE_BITS(30)) u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  distinct_count_scoreboard sb;

  // Percent of words after which the sender inserts a gap / of cycles in which the receiver stalls.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  // Long receiver hold-off: the stimulus posts a request, the receiver counts it down.
  int  hold_len = 0;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_cycles = 0;
  int  cycle_count = 0;
  // Small pool of values so that loads repeat and queries see duplicates.
  bit [29:0] value_pool [40];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: a stuck handshake or a runaway block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested. Each result word
  // accepted at this edge is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.data);
      if (hold_seq != hold_seen) begin
        hold_seen    <= hold_seq;
        hold_cycles  <= hold_len - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles  <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one word and waits for the edge where it is accepted. The valid line stays
  // high into the next word unless a gap is drawn, so back-to-back words are exercised.
  task automatic send_word(input logic [1:0] cmd, input bit [29:0] val,
                           input bit [11:0] qs, input bit [11:0] qe);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= {cmd, val, qs, qe};
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word({cmd, val, qs, qe});
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The sender goes quiet first, so the last word is not offered a second time.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A well-formed query somewhere inside the loaded array; mostly narrow windows that
  // drift, sometimes a wide one, so both the growing and shrinking paths are taken.
  task automatic send_good_query();
    int unsigned n;
    int unsigned a;
    int unsigned b;
    n = sb.loaded;
    a = $urandom_range(n - 1);
    if ($urandom_range(9) == 0) b = $urandom_range(n - 1);
    else b = a + $urandom_range(40);
    if (b >= n) b = n - 1;
    if (b < a) begin
      n = a;
      a = b;
      b = n;
    end
    send_word(rdc_pkg::CMD_QUERY, 30'($urandom), 12'(a), 12'(b));
  endtask

  task automatic send_random_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (sb.loaded > 300 && pick < 3) begin
      send_word(rdc_pkg::CMD_CLEAR, 30'($urandom), 12'($urandom), 12'($urandom));
    end else if (pick < 45 || sb.loaded == 0) begin
      if ($urandom_range(9) < 7) send_word(rdc_pkg::CMD_LOAD, value_pool[$urandom_range(39)],
                                           12'($urandom), 12'($urandom));
      else send_word(rdc_pkg::CMD_LOAD, 30'($urandom), 12'($urandom), 12'($urandom));
    end else if (pick < 88) begin
      send_good_query();
    end else if (pick < 95) begin
      // Random range, usually out of bounds or reversed.
      send_word(rdc_pkg::CMD_QUERY, 30'($urandom), 12'($urandom), 12'($urandom));
    end else if (pick < 98) begin
      send_word(rdc_pkg::CMD_UNUSED, 30'($urandom), 12'($urandom), 12'($urandom));
    end else begin
      send_word(rdc_pkg::CMD_CLEAR, 30'($urandom), 12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    sb = new();
    foreach (value_pool[i]) value_pool[i] = (i < 8) ? 30'(i) : 30'($urandom);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty-store queries, the unused command, the extremes of the
    // value field, the first query opening a window, moves in every direction, a load
    // with a window open, and a clear.
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_UNUSED, 30'h3FFFFFFF, 12'hFFF, 12'hFFF);
    send_word(rdc_pkg::CMD_LOAD, 30'd0, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_LOAD, 30'h3FFFFFFF, 12'hFFF, 12'hFFF);
    send_word(rdc_pkg::CMD_LOAD, 30'd0, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_LOAD, 30'h2AAAAAAA, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_LOAD, 30'h15555555, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd3, 12'd1);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd5);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd2, 12'd2);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd4);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd1, 12'd3);
    send_word(rdc_pkg::CMD_LOAD, 30'h3FFFFFFF, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd3, 12'd5);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_CLEAR, 30'd0, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_LOAD, 30'd7, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd0);

    // Load a short array from a few repeating values, then query the whole of it,
    // both ends and a reversed range.
    while (sb.loaded < 40)
      send_word(rdc_pkg::CMD_LOAD, value_pool[$urandom_range(3)], 12'($urandom),
                12'($urandom));
    send_word(rdc_pkg::CMD_LOAD, 30'd99, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd40);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd40, 12'd40);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'd0, 12'd0);
    send_word(rdc_pkg::CMD_QUERY, 30'd0, 12'hFFE, 12'hFFD);
    send_word(rdc_pkg::CMD_CLEAR, 30'd0, 12'd0, 12'd0);

    // Random part in three idling regimes.
    send_idle_pct  = 6;
    recv_stall_pct = 51;
    repeat (110) send_random_word();
    send_idle_pct  = 51;
    recv_stall_pct = 6;
    repeat (110) send_random_word();
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Back-pressure: the receiver holds off while words keep coming, so the block
    // must stall its input. Then the sender pauses until everything is out.
    hold_len = 400;
    hold_seq = hold_seq + 1;
    repeat (20) send_random_word();
    wait_drained();
    repeat (100) send_random_word();

    wait_drained();
    repeat (200) @(posedge clk);

    $display("Covered loads with repeated and extreme values, good and bad queries, clears,");
    $display("the unused command and long output stalls: %0d results checked, %0d mismatches.",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rdc_pkg.sv
hdl/rdc_if.sv
hdl/rdc_ram.sv
hdl/range_distinct_count_core.sv
dv/range_distinct_count_core_tb.sv
